// ===== rtl/sos_pkg.sv =====
// Package for the segment versus oriented box slab tester.
// Fixed-point widths, pipeline constants, divider step function and shared types.
// No dependencies.
package sos_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int AXIS_WIDTH  = 16;
   localparam int AXES        = 3;
   localparam int NUM_REGS    = 6;
   localparam int CSR_IDX_W   = 3;

   localparam int COORD_FRAC = COORD_WIDTH / 2;
   localparam int AXIS_FRAC  = AXIS_WIDTH - 2;
   localparam int T_FRAC     = 32;

   localparam int SIZE_W = COORD_WIDTH - 1;
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = DIFF_W + AXIS_WIDTH;
   localparam int DOT_W  = PROD_W + 2;
   localparam int NUM_W  = DOT_W + 1;
   localparam int MAG_W  = NUM_W;
   localparam int REM_W  = MAG_W + 1;
   localparam int HALF_W = SIZE_W + AXIS_FRAC - 1;

   localparam int QUO_W      = T_FRAC + 1;
   localparam int T_W        = T_FRAC + 3;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int LANES      = 2 * AXES;

   localparam int TLO_W = (QUO_W + 1) / 2;
   localparam int THI_W = QUO_W - TLO_W;
   localparam int ML_W  = DIFF_W + TLO_W + 1;
   localparam int MH_W  = DIFF_W + THI_W + 1;
   localparam int P_W   = DIFF_W + T_FRAC + 3;
   localparam int V_W   = P_W - T_FRAC + 1;

   localparam longint PAR_EPS_RAW =
      ((64'sd1 <<< (COORD_FRAC + AXIS_FRAC)) + 64'sd500000) / 64'sd1000000;
   localparam longint PAR_EPS = (PAR_EPS_RAW > 0) ? PAR_EPS_RAW : 64'sd1;

   // slab parameter limits: +2 stands for infinity, +1 is the segment end
   localparam logic signed [T_W-1:0] T_SAT = {2'b01, {(T_W-2){1'b0}}};
   localparam logic signed [T_W-1:0] T_ONE = {3'b001, {(T_W-3){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_Z = 3'd2,
      CSR_END_X   = 3'd3,
      CSR_END_Y   = 3'd4,
      CSR_END_Z   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [MAG_W-1:0] den;
      logic             neg;
      logic             sat;
   } div_lane_type;

   typedef struct packed {
      logic            box;
      logic [AXES-1:0] par;
      logic [AXES-1:0] parok;
   } side_type;

   // restoring division, DIV_STEPS quotient bits; first step takes no shift
   function automatic div_lane_type div_stage(div_lane_type x, int base);
      div_lane_type y;
      logic         bit_q;
      int           j;
      y = x;
      for (int m = 0; m < DIV_STEPS; m++) begin
         j = base + m;
         if (j < QUO_W) begin
            if (j > 0) y.rem = {y.rem[REM_W-2:0], 1'b0};
            bit_q = (y.rem >= REM_W'(y.den));
            if (bit_q) y.rem = y.rem - REM_W'(y.den);
            y.quo = {y.quo[QUO_W-2:0], bit_q};
         end
      end
      return y;
   endfunction

endpackage

// ===== rtl/segment_obb_slab_intersect_core.sv =====
// Segment versus oriented box slab tester, top level.
// Depends on sos_pkg.
//
// One box test per cycle: a new box is taken every cycle while rsp_ready is high. A box passes
// through 29 register stages: 5 for differences, products, dot products, slab numerators and
// magnitudes, 17 for the radix-4 divider pipeline that yields the six slab parameters, 4 for
// interval logic and 3 for the impact point. A stall on the result side freezes the whole
// pipeline; req_ready follows it. Segment registers are written over the csr port, which is
// always ready, and must only change while idle.
module segment_obb_slab_intersect_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_box_valid,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0]    req_box_center_x,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0]    req_box_center_y,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0]    req_box_center_z,
   input  logic [sos_pkg::SIZE_W-1:0]                req_box_size_x,
   input  logic [sos_pkg::SIZE_W-1:0]                req_box_size_y,
   input  logic [sos_pkg::SIZE_W-1:0]                req_box_size_z,
   input  logic [3*sos_pkg::AXIS_WIDTH-1:0]          req_axis_first,
   input  logic [3*sos_pkg::AXIS_WIDTH-1:0]          req_axis_second,
   input  logic [3*sos_pkg::AXIS_WIDTH-1:0]          req_axis_third,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_hit,
   output logic signed [sos_pkg::COORD_WIDTH-1:0]    rsp_impact_x,
   output logic signed [sos_pkg::COORD_WIDTH-1:0]    rsp_impact_y,
   output logic signed [sos_pkg::COORD_WIDTH-1:0]    rsp_impact_z,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [sos_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [sos_pkg::COORD_WIDTH-1:0]           csr_data
);
   import sos_pkg::*;

   localparam logic signed [V_W-1:0] LIM_HI = V_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [V_W-1:0] LIM_LO = -LIM_HI - V_W'(1);

   logic adv;

   // ---------------- configuration ----------------
   logic signed [COORD_WIDTH-1:0] cfg_ff [NUM_REGS];
   logic signed [DIFF_W-1:0]      seg_s [AXES];
   logic signed [DIFF_W-1:0]      seg_d [AXES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) cfg_ff[r] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_X: cfg_ff[0] <= csr_data;
            CSR_START_Y: cfg_ff[1] <= csr_data;
            CSR_START_Z: cfg_ff[2] <= csr_data;
            CSR_END_X:   cfg_ff[3] <= csr_data;
            CSR_END_Y:   cfg_ff[4] <= csr_data;
            CSR_END_Z:   cfg_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         seg_s[k] = DIFF_W'(cfg_ff[k]);
         seg_d[k] = DIFF_W'(cfg_ff[AXES+k]) - DIFF_W'(cfg_ff[k]);
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 0: offsets from segment start ----------------
   logic signed [COORD_WIDTH-1:0] center_in [AXES];
   logic [SIZE_W-1:0]             size_in [AXES];
   logic [3*AXIS_WIDTH-1:0]       axis_in [AXES];

   assign center_in[0] = req_box_center_x;
   assign center_in[1] = req_box_center_y;
   assign center_in[2] = req_box_center_z;
   assign size_in[0]   = req_box_size_x;
   assign size_in[1]   = req_box_size_y;
   assign size_in[2]   = req_box_size_z;
   assign axis_in[0]   = req_axis_first;
   assign axis_in[1]   = req_axis_second;
   assign axis_in[2]   = req_axis_third;

   logic                         s0_valid_ff;
   logic                         s0_box_ff;
   logic signed [DIFF_W-1:0]     s0_e_ff [AXES];
   logic [SIZE_W-1:0]            s0_size_ff [AXES];
   logic signed [AXIS_WIDTH-1:0] s0_ax_ff [AXES][AXES];

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (adv) s0_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_box_ff <= req_box_valid;
         for (int k = 0; k < AXES; k++) begin
            s0_e_ff[k]    <= DIFF_W'(center_in[k]) - seg_s[k];
            s0_size_ff[k] <= size_in[k];
            for (int c = 0; c < AXES; c++)
               s0_ax_ff[k][c] <= axis_in[k][(AXES-1-c)*AXIS_WIDTH +: AXIS_WIDTH];
         end
      end
   end

   // ---------------- stage 1: component products ----------------
   logic                     s1_valid_ff;
   logic                     s1_box_ff;
   logic signed [PROD_W-1:0] s1_pe_ff [AXES][AXES];
   logic signed [PROD_W-1:0] s1_pf_ff [AXES][AXES];
   logic [HALF_W-1:0]        s1_half_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= s0_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_box_ff <= s0_box_ff;
         for (int i = 0; i < AXES; i++) begin
            s1_half_ff[i] <= {s0_size_ff[i], {(AXIS_FRAC-1){1'b0}}};
            for (int c = 0; c < AXES; c++) begin
               s1_pe_ff[i][c] <= PROD_W'(s0_e_ff[c]) * PROD_W'(s0_ax_ff[i][c]);
               s1_pf_ff[i][c] <= PROD_W'(seg_d[c]) * PROD_W'(s0_ax_ff[i][c]);
            end
         end
      end
   end

   // ---------------- stage 2: dot products ----------------
   logic                    s2_valid_ff;
   logic                    s2_box_ff;
   logic signed [DOT_W-1:0] s2_ep_ff [AXES];
   logic signed [DOT_W-1:0] s2_fp_ff [AXES];
   logic [HALF_W-1:0]       s2_half_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_box_ff <= s1_box_ff;
         for (int i = 0; i < AXES; i++) begin
            s2_ep_ff[i]   <= DOT_W'(s1_pe_ff[i][0]) + DOT_W'(s1_pe_ff[i][1])
                             + DOT_W'(s1_pe_ff[i][2]);
            s2_fp_ff[i]   <= DOT_W'(s1_pf_ff[i][0]) + DOT_W'(s1_pf_ff[i][1])
                             + DOT_W'(s1_pf_ff[i][2]);
            s2_half_ff[i] <= s1_half_ff[i];
         end
      end
   end

   // ---------------- stage 3: slab numerators, |F| ----------------
   logic                    s3_valid_ff;
   logic                    s3_box_ff;
   logic signed [NUM_W-1:0] s3_nlo_ff [AXES];
   logic signed [NUM_W-1:0] s3_nhi_ff [AXES];
   logic [MAG_W-1:0]        s3_fabs_ff [AXES];
   logic [AXES-1:0]         s3_fneg_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_box_ff <= s2_box_ff;
         for (int i = 0; i < AXES; i++) begin
            s3_nlo_ff[i]  <= NUM_W'(s2_ep_ff[i]) - NUM_W'(s2_half_ff[i]);
            s3_nhi_ff[i]  <= NUM_W'(s2_ep_ff[i]) + NUM_W'(s2_half_ff[i]);
            s3_fabs_ff[i] <= (s2_fp_ff[i] < 0) ? MAG_W'(-s2_fp_ff[i]) : MAG_W'(s2_fp_ff[i]);
            s3_fneg_ff[i] <= s2_fp_ff[i][DOT_W-1];
         end
      end
   end

   // ---------------- stage 4: magnitudes and parallel check ----------------
   logic             s4_valid_ff;
   side_type         s4_side_ff;
   logic [MAG_W-1:0] s4_nabs_ff [LANES];
   logic [LANES-1:0] s4_neg_ff;
   logic [MAG_W-1:0] s4_fabs_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (adv) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff.box <= s3_box_ff;
         for (int i = 0; i < AXES; i++) begin
            s4_side_ff.par[i]   <= (s3_fabs_ff[i] < MAG_W'(PAR_EPS));
            // inside the slab: E - H <= 0 and E + H >= 0
            s4_side_ff.parok[i] <= (s3_nlo_ff[i] <= 0) && (s3_nhi_ff[i] >= 0);
            s4_nabs_ff[2*i]     <= (s3_nlo_ff[i] < 0) ? MAG_W'(-s3_nlo_ff[i])
                                                      : MAG_W'(s3_nlo_ff[i]);
            s4_nabs_ff[2*i+1]   <= (s3_nhi_ff[i] < 0) ? MAG_W'(-s3_nhi_ff[i])
                                                      : MAG_W'(s3_nhi_ff[i]);
            s4_neg_ff[2*i]      <= s3_nlo_ff[i][NUM_W-1] ^ s3_fneg_ff[i];
            s4_neg_ff[2*i+1]    <= s3_nhi_ff[i][NUM_W-1] ^ s3_fneg_ff[i];
            s4_fabs_ff[i]       <= s3_fabs_ff[i];
         end
      end
   end

   // ---------------- divider pipeline ----------------
   div_lane_type div_init [LANES];
   div_lane_type div_ff [DIV_STAGES][LANES];
   logic         dv_valid_ff [DIV_STAGES];
   side_type     dv_side_ff [DIV_STAGES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         div_init[l].rem = REM_W'(s4_nabs_ff[l]);
         div_init[l].quo = '0;
         div_init[l].den = s4_fabs_ff[l/2];
         div_init[l].neg = s4_neg_ff[l];
         // quotient of two or more saturates
         div_init[l].sat = ({1'b0, s4_nabs_ff[l]} >= {s4_fabs_ff[l/2], 1'b0});
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) dv_valid_ff[k] <= 1'b0;
            else if (adv) dv_valid_ff[k] <= s4_valid_ff;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_side_ff[k] <= s4_side_ff;
               for (int l = 0; l < LANES; l++)
                  div_ff[k][l] <= div_stage(div_init[l], 0);
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) dv_valid_ff[k] <= 1'b0;
            else if (adv) dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_side_ff[k] <= dv_side_ff[k-1];
               for (int l = 0; l < LANES; l++)
                  div_ff[k][l] <= div_stage(div_ff[k-1][l], k*DIV_STEPS);
            end
         end
      end
   end

   // ---------------- P1: signed slab parameters ----------------
   logic                p1_valid_ff;
   side_type            p1_side_ff;
   logic signed [T_W-1:0] p1_t_ff [LANES];
   logic signed [T_W-1:0] t_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (div_ff[DIV_STAGES-1][l].sat)
            t_in[l] = div_ff[DIV_STAGES-1][l].neg ? -T_SAT : T_SAT;
         else if (div_ff[DIV_STAGES-1][l].neg)
            // floor of a negative quotient rounds away when there is a remainder
            t_in[l] = -(T_W'(div_ff[DIV_STAGES-1][l].quo)
                        + T_W'(div_ff[DIV_STAGES-1][l].rem != '0));
         else
            t_in[l] = T_W'(div_ff[DIV_STAGES-1][l].quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else if (adv) p1_valid_ff <= dv_valid_ff[DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_side_ff <= dv_side_ff[DIV_STAGES-1];
         for (int l = 0; l < LANES; l++) p1_t_ff[l] <= t_in[l];
      end
   end

   // ---------------- P2: order each slab ----------------
   logic                  p2_valid_ff;
   side_type              p2_side_ff;
   logic signed [T_W-1:0] p2_lo_ff [AXES];
   logic signed [T_W-1:0] p2_hi_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) p2_valid_ff <= 1'b0;
      else if (adv) p2_valid_ff <= p1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_side_ff <= p1_side_ff;
         for (int i = 0; i < AXES; i++) begin
            if (p1_side_ff.par[i]) begin
               p2_lo_ff[i] <= -T_SAT;
               p2_hi_ff[i] <= T_SAT;
            end else if (p1_t_ff[2*i] > p1_t_ff[2*i+1]) begin
               p2_lo_ff[i] <= p1_t_ff[2*i+1];
               p2_hi_ff[i] <= p1_t_ff[2*i];
            end else begin
               p2_lo_ff[i] <= p1_t_ff[2*i];
               p2_hi_ff[i] <= p1_t_ff[2*i+1];
            end
         end
      end
   end

   // ---------------- P3: interval intersection ----------------
   logic                  p3_valid_ff;
   side_type              p3_side_ff;
   logic signed [T_W-1:0] p3_enter_ff;
   logic signed [T_W-1:0] p3_leave_ff;
   logic signed [T_W-1:0] enter_in;
   logic signed [T_W-1:0] leave_in;

   always_comb begin
      enter_in = p2_lo_ff[0];
      leave_in = p2_hi_ff[0];
      for (int i = 1; i < AXES; i++) begin
         if (p2_lo_ff[i] > enter_in) enter_in = p2_lo_ff[i];
         if (p2_hi_ff[i] < leave_in) leave_in = p2_hi_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p3_valid_ff <= 1'b0;
      else if (adv) p3_valid_ff <= p2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_side_ff  <= p2_side_ff;
         p3_enter_ff <= enter_in;
         p3_leave_ff <= leave_in;
      end
   end

   // ---------------- P4: decision ----------------
   logic             p4_valid_ff;
   logic             p4_hit_ff;
   logic [QUO_W-1:0] p4_t_ff;
   logic             hit_in;

   always_comb begin
      hit_in = p3_side_ff.box
               && ((p3_side_ff.parok | ~p3_side_ff.par) == {AXES{1'b1}})
               && !(p3_enter_ff > p3_leave_ff)
               && !(p3_leave_ff < 0)
               && !(p3_enter_ff > T_ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) p4_valid_ff <= 1'b0;
      else if (adv) p4_valid_ff <= p3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_hit_ff <= hit_in;
         p4_t_ff   <= (p3_enter_ff < 0) ? '0 : p3_enter_ff[QUO_W-1:0];
      end
   end

   // ---------------- M1: partial products d * t ----------------
   logic                   m1_valid_ff;
   logic                   m1_hit_ff;
   logic signed [ML_W-1:0] m1_lo_ff [AXES];
   logic signed [MH_W-1:0] m1_hi_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) m1_valid_ff <= 1'b0;
      else if (adv) m1_valid_ff <= p4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_hit_ff <= p4_hit_ff;
         for (int k = 0; k < AXES; k++) begin
            m1_lo_ff[k] <= ML_W'(seg_d[k])
                           * ML_W'($signed({1'b0, p4_t_ff[TLO_W-1:0]}));
            m1_hi_ff[k] <= MH_W'(seg_d[k])
                           * MH_W'($signed({1'b0, p4_t_ff[QUO_W-1:TLO_W]}));
         end
      end
   end

   // ---------------- M2: combine and round ----------------
   logic                  m2_valid_ff;
   logic                  m2_hit_ff;
   logic signed [P_W-1:0] m2_p_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) m2_valid_ff <= 1'b0;
      else if (adv) m2_valid_ff <= m1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_hit_ff <= m1_hit_ff;
         for (int k = 0; k < AXES; k++)
            m2_p_ff[k] <= (P_W'(m1_hi_ff[k]) <<< TLO_W) + P_W'(m1_lo_ff[k])
                          + (P_W'(1) <<< (T_FRAC - 1));
      end
   end

   // ---------------- output register ----------------
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic signed [COORD_WIDTH-1:0] rsp_impact_ff [AXES];
   logic signed [COORD_WIDTH-1:0] impact_in [AXES];
   logic signed [V_W-1:0]         v_sum;

   always_comb begin
      v_sum = '0;
      for (int k = 0; k < AXES; k++) begin
         v_sum = V_W'(m2_p_ff[k] >>> T_FRAC) + V_W'(seg_s[k]);
         if (!m2_hit_ff)          impact_in[k] = '0;
         else if (v_sum > LIM_HI) impact_in[k] = LIM_HI[COORD_WIDTH-1:0];
         else if (v_sum < LIM_LO) impact_in[k] = LIM_LO[COORD_WIDTH-1:0];
         else                     impact_in[k] = v_sum[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= m2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff <= m2_hit_ff;
         for (int k = 0; k < AXES; k++) rsp_impact_ff[k] <= impact_in[k];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_impact_x = rsp_impact_ff[0];
   assign rsp_impact_y = rsp_impact_ff[1];
   assign rsp_impact_z = rsp_impact_ff[2];

   // ---------------- assertions ----------------
   miss_zero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |->
         rsp_impact_ff[0] == '0 && rsp_impact_ff[1] == '0 && rsp_impact_ff[2] == '0)
      else $error("miss result carries a nonzero impact");

   stall_freeze_a: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable({s0_valid_ff, dv_valid_ff[0], p4_valid_ff, m2_valid_ff}))
      else $error("pipeline moved during a stall");

   hit_range_a: assert property (@(posedge clock) disable iff (reset)
      p4_valid_ff && p4_hit_ff |-> p4_t_ff <= QUO_W'(T_ONE))
      else $error("entry parameter beyond segment end on a hit");

endmodule

// ===== tb/sv/segment_obb_slab_intersect_checker.sv =====
// Checker for the segment versus oriented box slab tester: watches all three channels,
// predicts one result per box transfer and compares it with the result channel.
// Depends on sos_pkg.
module segment_obb_slab_intersect_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_box_valid,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0] req_box_center_x,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0] req_box_center_y,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0] req_box_center_z,
   input  logic [sos_pkg::SIZE_W-1:0]             req_box_size_x,
   input  logic [sos_pkg::SIZE_W-1:0]             req_box_size_y,
   input  logic [sos_pkg::SIZE_W-1:0]             req_box_size_z,
   input  logic [3*sos_pkg::AXIS_WIDTH-1:0]       req_axis_first,
   input  logic [3*sos_pkg::AXIS_WIDTH-1:0]       req_axis_second,
   input  logic [3*sos_pkg::AXIS_WIDTH-1:0]       req_axis_third,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic                                   rsp_hit,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0] rsp_impact_x,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0] rsp_impact_y,
   input  logic signed [sos_pkg::COORD_WIDTH-1:0] rsp_impact_z,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [sos_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sos_pkg::COORD_WIDTH-1:0]        csr_data,
   output int                                     errors,
   output int                                     pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sos_pkg::*;

   localparam longint PARAM_INF = longint'(1) <<< 33;
   localparam longint PARAM_ONE = longint'(1) <<< 32;

   typedef struct {
      logic                   hit;
      logic [COORD_WIDTH-1:0] pos [3];
   } impact_type;

   logic signed [COORD_WIDTH-1:0] seg_regs [NUM_REGS];
   impact_type                    impact_q [$];

   // floor(n * 2^32 / f), held to [-2, 2]
   function automatic longint slab_param(longint n, longint f);
      logic signed [127:0] an, af, q, r;
      logic                neg;
      neg = (n < 0) != (f < 0);
      an  = (n < 0) ? -n : n;
      af  = (f < 0) ? -f : f;
      if (an >= 2 * af) return neg ? -PARAM_INF : PARAM_INF;
      q = (an <<< 32) / af;
      r = (an <<< 32) - q * af;
      if (neg) return -longint'(q + ((r != 0) ? 1 : 0));
      return longint'(q);
   endfunction

   function automatic impact_type predict_impact(logic bvalid, logic signed [31:0] ctr [3],
                                                 logic [SIZE_W-1:0] sz [3],
                                                 logic [47:0] axes [3]);
      impact_type          res;
      longint              s [3], d [3], e [3], a [3];
      longint              enter, leave, half, ep, fp, t1, t2, tmp, t, v;
      logic signed [127:0] p;
      enter = -PARAM_INF;
      leave = PARAM_INF;
      res.hit = bvalid;
      for (int k = 0; k < 3; k++) begin
         s[k] = seg_regs[k];
         d[k] = longint'(seg_regs[3+k]) - s[k];
         e[k] = longint'(ctr[k]) - s[k];
         res.pos[k] = '0;
      end
      for (int i = 0; i < 3; i++) begin
         if (res.hit) begin
            a[0] = $signed(axes[i][47:32]);
            a[1] = $signed(axes[i][31:16]);
            a[2] = $signed(axes[i][15:0]);
            half = longint'(sz[i]) <<< (AXIS_FRAC - 1);
            ep = e[0] * a[0] + e[1] * a[1] + e[2] * a[2];
            fp = d[0] * a[0] + d[1] * a[1] + d[2] * a[2];
            if (((fp < 0) ? -fp : fp) < PAR_EPS) begin
               if (ep < -half || ep > half) res.hit = 1'b0;
            end else begin
               t1 = slab_param(ep - half, fp);
               t2 = slab_param(ep + half, fp);
               if (t1 > t2) begin
                  tmp = t1; t1 = t2; t2 = tmp;
               end
               if (t1 > enter) enter = t1;
               if (t2 < leave) leave = t2;
               if (enter > leave || leave < 0) res.hit = 1'b0;
            end
         end
      end
      if (res.hit && (enter > PARAM_ONE || leave < 0)) res.hit = 1'b0;
      if (res.hit) begin
         t = (enter < 0) ? 0 : enter;
         for (int k = 0; k < 3; k++) begin
            p = 128'(d[k]) * 128'(t) + (128'sd1 <<< 31);
            v = longint'(p >>> 32) + s[k];
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            res.pos[k] = v[31:0];
         end
      end
      return res;
   endfunction

   assign pending = impact_q.size();

   always @(posedge clock) begin
      impact_type got, want;
      logic signed [31:0] ctr [3];
      logic [SIZE_W-1:0]  sz [3];
      logic [47:0]        axes [3];
      int                 fails;
      fails = 0;
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) seg_regs[k] <= '0;
         errors <= 0;
         impact_q.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < NUM_REGS) seg_regs[csr_index] <= csr_data;
         if (req_valid && req_ready) begin
            ctr  = '{req_box_center_x, req_box_center_y, req_box_center_z};
            sz   = '{req_box_size_x, req_box_size_y, req_box_size_z};
            axes = '{req_axis_first, req_axis_second, req_axis_third};
            impact_q.push_back(predict_impact(req_box_valid, ctr, sz, axes));
         end
         if (rsp_valid && rsp_ready) begin
            if (impact_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fails++;
            end else begin
               want = impact_q.pop_front();
               got.hit = rsp_hit;
               got.pos = '{rsp_impact_x, rsp_impact_y, rsp_impact_z};
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                  fails++;
               end else begin
                  for (int k = 0; k < 3; k++)
                     if (got.pos[k] !== want.pos[k]) begin
                        $error("impact_%s: expected %0d, actual %0d",
                               (k == 0) ? "x" : (k == 1) ? "y" : "z",
                               $signed(want.pos[k]), $signed(got.pos[k]));
                        fails++;
                     end
               end
            end
         end
         if (fails != 0) errors <= errors + fails;
      end
   end

endmodule

// ===== tb/sv/segment_obb_slab_intersect_core_tb.sv =====
// Top of the testbench for segment_obb_slab_intersect_core: clock, reset, segment set-ups
// and box stimulus with bursty sender and stalling receiver; verdict from the checker.
// Depends on sos_pkg, segment_obb_slab_intersect_core and segment_obb_slab_intersect_checker.
module segment_obb_slab_intersect_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sos_pkg::*;

   localparam logic [15:0] AX_ONE  = 16'sd16384;
   localparam logic [15:0] AX_MONE = -16'sd16384;
   localparam int          DRAIN   = 60;

   logic                          clock, reset;
   logic                          req_valid, req_ready, req_box_valid;
   logic signed [COORD_WIDTH-1:0] req_box_center_x, req_box_center_y, req_box_center_z;
   logic [SIZE_W-1:0]             req_box_size_x, req_box_size_y, req_box_size_z;
   logic [3*AXIS_WIDTH-1:0]       req_axis_first, req_axis_second, req_axis_third;
   logic                          rsp_valid, rsp_ready, rsp_hit;
   logic signed [COORD_WIDTH-1:0] rsp_impact_x, rsp_impact_y, rsp_impact_z;
   logic                          csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [COORD_WIDTH-1:0]        csr_data;
   int                            errors, pending;
   int                            burst_left, stall_mode, stall_left;
   logic signed [31:0]            seg_s [3], seg_p [3];

   segment_obb_slab_intersect_core u_top (.*);
   segment_obb_slab_intersect_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: stretches of always ready, random stalls or long stalls
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(5, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_segment(logic signed [31:0] s [3], logic signed [31:0] p [3]);
      wait_idle();
      write_reg(CSR_START_X, s[0]);
      write_reg(CSR_START_Y, s[1]);
      write_reg(CSR_START_Z, s[2]);
      write_reg(CSR_END_X, p[0]);
      write_reg(CSR_END_Y, p[1]);
      write_reg(CSR_END_Z, p[2]);
      // out-of-range index must be ignored
      write_reg(3'(NUM_REGS + $urandom_range(0, 1)), $urandom);
      seg_s = s;
      seg_p = p;
   endtask

   task automatic send_box(logic bv, logic signed [31:0] c [3], logic [30:0] sz [3],
                           logic [47:0] a0, logic [47:0] a1, logic [47:0] a2);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_box_valid    <= bv;
      req_box_center_x <= c[0];
      req_box_center_y <= c[1];
      req_box_center_z <= c[2];
      req_box_size_x   <= sz[0];
      req_box_size_y   <= sz[1];
      req_box_size_z   <= sz[2];
      req_axis_first   <= a0;
      req_axis_second  <= a1;
      req_axis_third   <= a2;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [47:0] pack_axis(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      return {x, y, z};
   endfunction

   // axis-aligned frame with random signs, optionally permuted
   task automatic aligned_frame(output logic [47:0] a [3]);
      logic [15:0] u [3];
      int          sh;
      sh = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         u = '{16'd0, 16'd0, 16'd0};
         u[(i + sh) % 3] = $urandom_range(0, 1) ? AX_ONE : AX_MONE;
         a[i] = pack_axis(u[0], u[1], u[2]);
      end
   endtask

   task automatic random_box();
      logic signed [31:0] c [3];
      logic [30:0]        sz [3];
      logic [47:0]        a [3];
      longint             frac;
      int                 kind;
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
         // fully random noise
         foreach (c[k]) c[k] = $urandom;
         foreach (sz[k]) sz[k] = 31'($urandom);
         foreach (a[k]) a[k] = 48'({$urandom, $urandom});
      end else begin
         // box placed near a point on or around the segment
         frac = $urandom_range(0, 1400) - 200;
         foreach (c[k])
            c[k] = 32'(longint'(seg_s[k]) + (longint'(seg_p[k]) - seg_s[k]) * frac / 1000
                       + $signed($urandom_range(0, 1 << 19)) - (1 << 18));
         foreach (sz[k]) sz[k] = 31'($urandom_range(0, (kind < 6) ? 2000 : (1 << 20)));
         case ($urandom_range(0, 4))
            0, 1: aligned_frame(a);
            2: foreach (a[k]) a[k] = pack_axis(16'($urandom_range(0, 32767) - 16384),
                                               16'($urandom_range(0, 32767) - 16384),
                                               16'($urandom_range(0, 32767) - 16384));
            3: begin
               aligned_frame(a);
               a[$urandom_range(0, 2)] = '0;
            end
            default: foreach (a[k]) a[k] = 48'({$urandom, $urandom});
         endcase
      end
      send_box($urandom_range(0, 9) != 0, c, sz, a[0], a[1], a[2]);
   endtask

   task automatic directed_boxes();
      logic signed [31:0] c [3], cmax [3], cmin [3];
      logic [30:0]        sz [3], szmax [3], sz0 [3];
      logic [47:0]        ex, ey, ez;
      ex = pack_axis(AX_ONE, 0, 0);
      ey = pack_axis(0, AX_ONE, 0);
      ez = pack_axis(0, 0, AX_ONE);
      cmax  = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      cmin  = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
      szmax = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
      sz0   = '{31'd0, 31'd0, 31'd0};
      c = '{32'sd0, 32'sd0, 32'sd0};
      sz = '{31'd65536 * 4, 31'd65536 * 4, 31'd65536 * 4};
      // invalid box, then the same box valid, both centred at the origin
      send_box(1'b0, c, sz, ex, ey, ez);
      send_box(1'b1, c, sz, ex, ey, ez);
      // box straddling the segment end; box beyond it
      c = seg_p;
      send_box(1'b1, c, sz, ex, ey, ez);
      c = '{seg_p[0] + 32'sd65536 * 8, seg_p[1], seg_p[2]};
      send_box(1'b1, c, sz, ex, ey, ez);
      // box behind the start
      c = '{seg_s[0] - 32'sd65536 * 8, seg_s[1], seg_s[2]};
      send_box(1'b1, c, sz, ex, ey, ez);
      // extremes of centre, size and axis components
      send_box(1'b1, cmax, szmax, ex, ey, ez);
      send_box(1'b1, cmin, szmax, ex, ey, ez);
      send_box(1'b1, cmax, sz0, ex, ey, ez);
      send_box(1'b1, cmin, sz0, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}});
      send_box(1'b1, cmax, szmax, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}});
      send_box(1'b1, seg_s, sz0, ex, ey, ez);
      // zero axes: every slab passes
      send_box(1'b1, cmin, sz0, '0, '0, '0);
      // negative axes, rotated frame
      c = '{(seg_s[0] >>> 1) + (seg_p[0] >>> 1), (seg_s[1] >>> 1) + (seg_p[1] >>> 1),
            (seg_s[2] >>> 1) + (seg_p[2] >>> 1)};
      send_box(1'b1, c, sz, pack_axis(AX_MONE, 0, 0), pack_axis(0, 0, AX_MONE), ey);
      send_box(1'b1, c, sz, pack_axis(16'sd11585, 16'sd11585, 0),
               pack_axis(-16'sd11585, 16'sd11585, 0), ez);
      send_box(1'b1, c, szmax, pack_axis(16'sd11585, 16'sd11585, 0),
               pack_axis(-16'sd11585, 16'sd11585, 0), ez);
   endtask

   task automatic run_phase(int n, logic signed [31:0] s [3], logic signed [31:0] p [3]);
      set_segment(s, p);
      directed_boxes();
      for (int i = 0; i < n; i++) begin
         random_box();
         if (i == n / 2 && $urandom_range(0, 1)) begin
            req_valid <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic random_point(output logic signed [31:0] v [3], input int span);
      foreach (v[k]) v[k] = $signed($urandom_range(0, 1 << span)) - (1 << (span - 1));
   endtask

   initial begin
      logic signed [31:0] s [3], p [3];
      reset = 1'b1;
      req_valid = 1'b0; req_box_valid = 1'b0;
      req_box_center_x = '0; req_box_center_y = '0; req_box_center_z = '0;
      req_box_size_x = '0; req_box_size_y = '0; req_box_size_z = '0;
      req_axis_first = '0; req_axis_second = '0; req_axis_third = '0;
      rsp_ready = 1'b0; csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      burst_left = 0; stall_mode = 0; stall_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ordinary segment
      random_point(s, 22); random_point(p, 22);
      run_phase(450, s, p);
      // degenerate segment: start equals end
      random_point(s, 20); p = s;
      run_phase(250, s, p);
      // axis-parallel segment, so many slabs are parallel
      random_point(s, 22); p = s; p[0] = s[0] + 32'sd65536 * 20;
      run_phase(300, s, p);
      // extremes of the registers
      s = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
      p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      run_phase(200, s, p);
      // short segment
      random_point(s, 18); random_point(p, 12);
      foreach (p[k]) p[k] = p[k] + s[k];
      run_phase(250, s, p);
      // back to zero segment
      s = '{32'sd0, 32'sd0, 32'sd0}; p = s;
      run_phase(150, s, p);

      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("segment_obb_slab_intersect_core_tb: PASS");
      else
         $display("segment_obb_slab_intersect_core_tb: FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("segment_obb_slab_intersect_core_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sos_pkg.sv
rtl/segment_obb_slab_intersect_core.sv
tb/sv/segment_obb_slab_intersect_checker.sv
tb/sv/segment_obb_slab_intersect_core_tb.sv
